>>> sv/stereo_panner_with_envelope_defines.svh
// ----------------------------------------------------------------------------
// Stereo panner assertion macros
// Shared concurrent assertion forms used by the panner's checks.
// ----------------------------------------------------------------------------
`ifndef STEREO_PANNER_WITH_ENVELOPE_DEFINES_SVH
`define STEREO_PANNER_WITH_ENVELOPE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/spe_pkg.sv
// ----------------------------------------------------------------------------
// Stereo panner package
// Shared types, codes and constant functions of the stereo panner.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PAN_POSITION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LAW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_SYNC    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_INPUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BP_COUNT     = 3'd5;

	localparam logic [1:0] CMD_AUDIO    = 2'd0;
	localparam logic [1:0] CMD_ENTRY    = 2'd1;
	localparam logic [1:0] CMD_PLAYTIME = 2'd2;

	localparam int PAN_MAX = 32767;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Divider operand widths: segment product and 33-bit time difference.
	localparam int NUM_W = 50;
	localparam int DEN_W = 33;

	typedef struct packed {
		logic [31:0]        time_s;
		logic signed [15:0] value;
	} bp_entry_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [NUM_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [15:0] clamp_pan(input logic signed [50:0] p);
		if (p > 51'(PAN_MAX)) begin
			return 16'(PAN_MAX);
		end else if (p < -51'(PAN_MAX)) begin
			return -16'(PAN_MAX);
		end
		return p[15:0];
	endfunction

	// Taylor series of sin(x), x in Q30 radians, rounded to Q0.16 and saturated.
	function automatic logic [15:0] sine_q16(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		logic        neg;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		neg  = 1'b1;
		for (int n = 3; n <= 13; n += 2) begin
			term = ((term * x2) >> 30) / 64'((n - 1) * n);
			if (neg) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
			neg = !neg;
		end
		v = (sum + 64'd8192) >> 14;
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

>>> sv/spe_div.sv
// ----------------------------------------------------------------------------
// Stereo panner divider
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module spe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  spe_pkg::div_req_t req,
	output spe_pkg::div_rsp_t rsp
);
	import spe_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dmag_q;
	logic [NUM_W-1:0] quo_q;

	logic [NUM_W-1:0] nmag;
	logic [DEN_W-1:0] dmag;
	logic [DEN_W:0]   trial;
	logic             take;

	assign nmag  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign dmag  = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign take  = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= nmag;
			dmag_q <= dmag;
			rem_q  <= '0;
			neg_q  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
		end else if (busy_q) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, dmag_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> sv/stereo_panner_with_envelope.sv
// ----------------------------------------------------------------------------
// Stereo panner with envelope
// Pans mono or stereo samples with a linear or constant power law, driven by
// a smoothed manual position or by a breakpoint envelope in a table memory.
// ----------------------------------------------------------------------------
// The block takes one item at a time. An item with command audio returns one
// result item; entry writes, play time writes and the unused command return
// none. An audio item in manual mode with a settled pan passes from acceptance
// through the smoothing, gain, scaling and output states to the output
// register under the linear law, and under the constant power law also through
// the table read states, because the quarter-sine table is read four times
// through its single registered read port. A new manual target that starts a
// ramp adds the step division in the shared bit-serial divider. In sync mode
// each segment the time index moves forward across costs a table read and a
// time check, and locating the segment and forming the interpolation terms
// takes the place of the smoothing step; past the last entry only the last
// entry is read, and a one-entry table skips it. A segment with non-zero
// length adds the same division. A finished result waits in the output
// register while the next item is accepted and worked on.
`include "stereo_panner_with_envelope_defines.svh"

module stereo_panner_with_envelope #(
	parameter int TABLE_DEPTH  = 64,
	parameter int SAMPLE_BITS  = 24,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      command,
	input  logic signed [SAMPLE_BITS-1:0]   left_in,
	input  logic signed [SAMPLE_BITS-1:0]   right_in,
	input  logic [5:0]                      entry_index,
	input  logic [31:0]                     entry_time,
	input  logic signed [15:0]              entry_value,
	input  logic [31:0]                     play_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_BITS-1:0]   left_out,
	output logic signed [SAMPLE_BITS-1:0]   right_out,
	output logic signed [15:0]              pan_used
);
	import spe_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int RA_W = $clog2(SINE_ENTRIES + 1);
	localparam int PW   = SAMPLE_BITS + 18;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DIV_RAMP = 4'd1;
	localparam logic [3:0] ST_SMOOTH   = 4'd2;
	localparam logic [3:0] ST_WALK_RD  = 4'd3;
	localparam logic [3:0] ST_WALK_CHK = 4'd4;
	localparam logic [3:0] ST_LAST     = 4'd5;
	localparam logic [3:0] ST_SEG_L    = 4'd6;
	localparam logic [3:0] ST_MUL      = 4'd7;
	localparam logic [3:0] ST_DIV_SEG  = 4'd8;
	localparam logic [3:0] ST_GAIN     = 4'd9;
	localparam logic [3:0] ST_ROM0     = 4'd10;
	localparam logic [3:0] ST_ROM1     = 4'd11;
	localparam logic [3:0] ST_ROM2     = 4'd12;
	localparam logic [3:0] ST_SCALE_L  = 4'd13;
	localparam logic [3:0] ST_SCALE_R  = 4'd14;
	localparam logic [3:0] ST_OUT      = 4'd15;

	// Configuration registers.
	logic signed [15:0] pan_pos_q;
	logic               law_q;
	logic               sync_q;
	logic               mono_q;
	logic [15:0]        ramp_q;
	logic [CW-1:0]      bp_count_q;

	// Envelope and smoothing state.
	logic [AW-1:0]      seg_q;
	logic [31:0]        time_q;
	logic signed [31:0] cur_q;
	logic signed [15:0] tgt_q;
	logic signed [32:0] step_q;
	logic [15:0]        cd_q;

	logic [3:0]         state_q;
	logic               side_q;
	logic               out_valid_q;

	// Per-item working registers.
	logic [31:0]                   t_q;
	logic signed [SAMPLE_BITS-1:0] li_q;
	logic signed [SAMPLE_BITS-1:0] ri_q;
	logic signed [15:0]            pan_q;
	bp_entry_t                     r_q;
	logic signed [15:0]            lval_q;
	logic signed [32:0]            den_q;
	logic signed [32:0]            num_q;
	logic signed [16:0]            dv_q;
	logic [RA_W-1:0]               idx_l_q;
	logic [RA_W-1:0]               idx_r_q;
	logic [15:0]                   frac_l_q;
	logic [15:0]                   frac_r_q;
	logic [15:0]                   a_q;
	logic [16:0]                   gl_q;
	logic [16:0]                   gr_q;
	logic signed [SAMPLE_BITS-1:0] lres_q;
	logic signed [SAMPLE_BITS-1:0] rres_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;
	logic signed [15:0]            pan_out_q;

	// Breakpoint table and sine table.
	bp_entry_t     bp_mem [TABLE_DEPTH];
	bp_entry_t     bp_rdata_q;
	logic [AW-1:0] bp_raddr;
	logic          bp_we;
	bp_entry_t     bp_wdata;
	logic [15:0]   sine_rom [SINE_ENTRIES+1];
	logic [15:0]   rom_q;
	logic [RA_W-1:0] rom_addr;

	logic               accept;
	logic               sync_mode;
	logic               out_free;
	logic               seg_next_ok;
	logic signed [15:0] pan_tgt;
	logic signed [32:0] ramp_diff;
	logic signed [32:0] cur_sum;
	logic signed [32:0] cur_shift;
	logic signed [32:0] cur_trunc;
	logic signed [15:0] smooth_pan;
	logic signed [49:0] prod;
	logic signed [15:0] seg_pan;
	logic [15:0]        u_r;
	logic [16:0]        u_l;
	logic [31:0]        pos_r;
	logic [31:0]        pos_l;
	logic [15:0]        frac_sel;
	logic [RA_W-1:0]    idx_sel;
	logic [15:0]        blend_diff;
	logic [31:0]        blend_p;
	logic [16:0]        blend_g;
	logic signed [SAMPLE_BITS-1:0] mul_s;
	logic [16:0]        mul_g;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] scaled;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign sync_mode = sync_q && (bp_count_q != '0);
	assign out_free  = !out_valid_q || out_ready;

	// Manual target and its ramp step numerator.
	assign pan_tgt   = clamp_pan(51'(pan_pos_q));
	assign ramp_diff = (33'(pan_tgt) <<< 16) - 33'(cur_q);

	// One smoothing step; pan is current / 65536 truncated toward zero.
	assign cur_sum    = 33'(cur_q) + step_q;
	assign cur_shift  = cur_sum >>> 16;
	assign cur_trunc  = (cur_sum[32] && (cur_sum[15:0] != 16'd0)) ? cur_shift + 33'sd1
	                                                              : cur_shift;
	assign smooth_pan = clamp_pan(51'(cur_trunc));

	// Segment interpolation.
	assign seg_next_ok = (int'(seg_q) + 1) < int'(bp_count_q);
	assign prod        = dv_q * num_q;
	assign seg_pan     = clamp_pan(51'(lval_q) + 51'(div_rsp.quot));

	always_comb begin
		bp_raddr = seg_q;
		if (state_q == ST_WALK_RD) begin
			bp_raddr = seg_next_ok ? AW'(seg_q + 1'b1) : AW'(bp_count_q - 1'b1);
		end
	end

	assign bp_we          = accept && (command == CMD_ENTRY) && (int'(entry_index) < TABLE_DEPTH);
	assign bp_wdata.time_s = entry_time;
	assign bp_wdata.value  = clamp_pan(51'(entry_value));

	// Writes happen only while idle, so they never meet the reads of the segment walk.
	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[AW'(entry_index)] <= bp_wdata;
		end
		bp_rdata_q <= bp_mem[bp_raddr];
	end

	// Divider requests: the ramp step at acceptance, the segment quotient in state MUL.
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = 50'(ramp_diff);
		div_req.den   = $signed({17'd0, ramp_q});
		if (state_q == ST_MUL) begin
			div_req.start = (den_q != 33'sd0);
			div_req.num   = prod;
			div_req.den   = den_q;
		end else if (state_q == ST_IDLE) begin
			div_req.start = accept && (command == CMD_AUDIO) && !sync_mode &&
			                (pan_tgt != tgt_q) && (ramp_q != 16'd0);
		end
	end

	spe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Quarter-sine table, built at elaboration.
	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		localparam logic [63:0] ANGLE = (64'(k) * PI_Q30) / 64'(2 * SINE_ENTRIES);
		assign sine_rom[k] = sine_q16(ANGLE);
	end

	// Gain lookup: position = u * entries, integer part indexes, low 16 bits blend.
	assign u_r   = pan_q ^ 16'h8000;
	assign u_l   = 17'h10000 - 17'(u_r);
	assign pos_r = 32'(u_r) * 32'(SINE_ENTRIES);
	assign pos_l = 32'(u_l) * 32'(SINE_ENTRIES);

	assign idx_sel  = side_q ? idx_r_q : idx_l_q;
	assign frac_sel = side_q ? frac_r_q : frac_l_q;

	always_comb begin
		rom_addr = idx_sel;
		if (state_q == ST_ROM1) begin
			rom_addr = idx_sel + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= sine_rom[rom_addr];
	end

	assign blend_diff = (rom_q >= a_q) ? rom_q - a_q : a_q - rom_q;
	assign blend_p    = 32'(blend_diff) * 32'(frac_sel);
	assign blend_g    = (rom_q >= a_q) ? 17'(a_q) + 17'(blend_p[31:16])
	                                   : 17'(a_q) - 17'(blend_p[31:16]);

	// Output scaling, shared between the two channels; rounds half up.
	assign mul_s  = (state_q == ST_SCALE_L) ? li_q : ri_q;
	assign mul_g  = (state_q == ST_SCALE_L) ? gl_q : gr_q;
	assign mul_p  = mul_s * $signed({1'b0, mul_g});
	assign scaled = mul_p + PW'(32768);

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_pos_q   <= '0;
			law_q       <= 1'b1;
			sync_q      <= 1'b0;
			mono_q      <= 1'b0;
			ramp_q      <= 16'd2400;
			bp_count_q  <= '0;
			seg_q       <= '0;
			time_q      <= '0;
			cur_q       <= '0;
			tgt_q       <= '0;
			step_q      <= '0;
			cd_q        <= '0;
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken one clears it.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (command)
							CMD_AUDIO: begin
								if (sync_mode) begin
									time_q  <= time_q + 1'b1;
									state_q <= (bp_count_q == CW'(1)) ? ST_GAIN : ST_WALK_RD;
								end else if (pan_tgt == tgt_q) begin
									state_q <= ST_SMOOTH;
								end else if (ramp_q == 16'd0) begin
									tgt_q   <= pan_tgt;
									cur_q   <= 32'(pan_tgt) <<< 16;
									cd_q    <= '0;
									state_q <= ST_SMOOTH;
								end else begin
									tgt_q   <= pan_tgt;
									cd_q    <= ramp_q;
									state_q <= ST_DIV_RAMP;
								end
							end
							CMD_PLAYTIME: begin
								time_q <= play_time;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV_RAMP: begin
					if (div_rsp.done) begin
						step_q  <= div_rsp.quot[32:0];
						state_q <= ST_SMOOTH;
					end
				end
				ST_SMOOTH: begin
					if (cd_q != 16'd0) begin
						cd_q <= cd_q - 1'b1;
						if (cd_q != 16'd1) begin
							cur_q <= cur_sum[31:0];
						end else begin
							cur_q <= 32'(tgt_q) <<< 16;
						end
					end
					state_q <= ST_GAIN;
				end
				ST_WALK_RD: begin
					state_q <= seg_next_ok ? ST_WALK_CHK : ST_LAST;
				end
				ST_WALK_CHK: begin
					if (t_q > bp_rdata_q.time_s) begin
						seg_q   <= seg_q + 1'b1;
						state_q <= ST_WALK_RD;
					end else begin
						state_q <= ST_SEG_L;
					end
				end
				ST_LAST: begin
					state_q <= ST_GAIN;
				end
				ST_SEG_L: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= (den_q == 33'sd0) ? ST_GAIN : ST_DIV_SEG;
				end
				ST_DIV_SEG: begin
					if (div_rsp.done) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					side_q  <= 1'b0;
					state_q <= law_q ? ST_ROM0 : ST_SCALE_L;
				end
				ST_ROM0: begin
					state_q <= ST_ROM1;
				end
				ST_ROM1: begin
					state_q <= ST_ROM2;
				end
				ST_ROM2: begin
					if (side_q) begin
						state_q <= ST_SCALE_L;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_ROM0;
					end
				end
				ST_SCALE_L: begin
					state_q <= ST_SCALE_R;
				end
				ST_SCALE_R: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register writes must arrive only while the sequencer is idle; the block does not enforce this.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PAN_POSITION: pan_pos_q <= $signed(cfg_data);
					REG_PAN_LAW:      law_q     <= cfg_data[0];
					REG_HOST_SYNC:    sync_q    <= cfg_data[0];
					REG_MONO_INPUT:   mono_q    <= cfg_data[0];
					REG_RAMP_STEPS: begin
						ramp_q <= cfg_data;
						cur_q  <= 32'(tgt_q) <<< 16;
						cd_q   <= '0;
					end
					REG_BP_COUNT: begin
						if (int'(cfg_data[6:0]) > TABLE_DEPTH) begin
							bp_count_q <= CW'(TABLE_DEPTH);
						end else begin
							bp_count_q <= CW'(cfg_data[6:0]);
						end
						seg_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (command == CMD_AUDIO)) begin
					li_q  <= left_in;
					ri_q  <= mono_q ? left_in : right_in;
					t_q   <= time_q;
					pan_q <= '0;
				end
			end
			ST_SMOOTH: begin
				if (cd_q == 16'd0 || cd_q == 16'd1) begin
					pan_q <= tgt_q;
				end else begin
					pan_q <= smooth_pan;
				end
			end
			ST_WALK_CHK: begin
				r_q <= bp_rdata_q;
			end
			ST_LAST: begin
				pan_q <= bp_rdata_q.value;
			end
			ST_SEG_L: begin
				lval_q <= bp_rdata_q.value;
				den_q  <= $signed({1'b0, r_q.time_s}) - $signed({1'b0, bp_rdata_q.time_s});
				num_q  <= $signed({1'b0, t_q}) - $signed({1'b0, bp_rdata_q.time_s});
				dv_q   <= 17'(r_q.value) - 17'(bp_rdata_q.value);
			end
			ST_MUL: begin
				if (den_q == 33'sd0) begin
					pan_q <= r_q.value;
				end
			end
			ST_DIV_SEG: begin
				if (div_rsp.done) begin
					pan_q <= seg_pan;
				end
			end
			ST_GAIN: begin
				idx_r_q  <= pos_r[16+RA_W-1:16];
				idx_l_q  <= pos_l[16+RA_W-1:16];
				frac_r_q <= pos_r[15:0];
				frac_l_q <= pos_l[15:0];
				gl_q     <= u_l;
				gr_q     <= 17'(u_r);
			end
			ST_ROM1: begin
				a_q <= rom_q;
			end
			ST_ROM2: begin
				if (side_q) begin
					gr_q <= blend_g;
				end else begin
					gl_q <= blend_g;
				end
			end
			ST_SCALE_L: begin
				lres_q <= scaled[SAMPLE_BITS+15:16];
			end
			ST_SCALE_R: begin
				rres_q <= scaled[SAMPLE_BITS+15:16];
			end
			ST_OUT: begin
				if (out_free) begin
					left_out_q  <= lres_q;
					right_out_q <= rres_q;
					pan_out_q   <= pan_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign pan_used  = pan_out_q;

	// Pan is clamped on every path, so full-scale negative never leaves the block.
	`SPE_ASSERT_NOW(a_pan_sym, clk, arst_n, out_valid, pan_used != 16'sh8000, "pan out of range")
	// The segment index stays inside the valid part of the table.
	`SPE_ASSERT_NOW(a_seg_bound, clk, arst_n, bp_count_q != '0, int'(seg_q) < int'(bp_count_q), "segment index past count")
	// A ramp never runs longer than the configured step count.
	`SPE_ASSERT_NOW(a_ramp_bound, clk, arst_n, 1'b1, cd_q <= ramp_q, "ramp countdown exceeds ramp steps")
	// The divider only finishes while the sequencer waits for it.
	`SPE_ASSERT_NOW(a_div_wait, clk, arst_n, div_rsp.done, (state_q == ST_DIV_RAMP) || (state_q == ST_DIV_SEG), "divider result unexpected")
	// A result leaving the sequencer shows up on the output.
	`SPE_ASSERT_NEXT(a_out_load, clk, arst_n, (state_q == ST_OUT) && out_free, out_valid, "result not presented")

endmodule

>>> sim/stereo_panner_with_envelope_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo panner with envelope testbench
// Drives audio, breakpoint and play time items through the valid/ready
// handshake, predicts every panned sample in a scoreboard and compares the
// outputs field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module stereo_panner_with_envelope_tb;
	import spe_pkg::*;

	localparam int DEPTH     = 64;
	localparam int ROM_SIZE  = 1024;
	localparam int IDLE_LIMIT = 20000;

	// Command code that the block ignores.
	localparam logic [1:0] CMD_NONE = 2'd3;

	// One input item as the sender presents it.
	typedef struct {
		logic [1:0]         cmd;
		logic signed [23:0] l;
		logic signed [23:0] r;
		logic [5:0]         idx;
		logic [31:0]        et;
		logic signed [15:0] ev;
		logic [31:0]        pt;
	} pan_item_t;

	// One panned sample as the block should return it.
	typedef struct {
		logic signed [23:0] l;
		logic signed [23:0] r;
		logic signed [15:0] pan;
	} pan_sample_t;

	// Scoreboard: keeps its own copy of the panner state and the expected
	// samples in the order the block must return them.
	class pan_scoreboard;
		int             fails;
		pan_sample_t    due[$];
		longint         rom[ROM_SIZE + 1];
		int             pan_pos, law, sync_on, mono, ramp, bp_count;
		longint unsigned bp_time[DEPTH];
		int             bp_val[DEPTH];
		int             seg;
		logic [31:0]    now;
		longint         cur, step;
		int             tgt, countdown;

		function new();
			longint unsigned x, x2, term, sum, v;
			bit neg;
			for (int k = 0; k <= ROM_SIZE; k++) begin
				x = longint'(k) * 64'd3373259426 / (2 * ROM_SIZE);
				x2 = (x * x) >> 30;
				term = x;
				sum = x;
				neg = 1;
				for (int n = 3; n <= 13; n += 2) begin
					term = ((term * x2) >> 30) / longint'((n - 1) * n);
					sum = neg ? sum - term : sum + term;
					neg = !neg;
				end
				v = (sum + 8192) >> 14;
				rom[k] = (v > 65535) ? 65535 : v;
			end
			fails = 0;
			pan_pos = 0; law = 1; sync_on = 0; mono = 0; ramp = 2400; bp_count = 0;
			seg = 0; now = 0; cur = 0; step = 0; tgt = 0; countdown = 0;
			foreach (bp_time[i]) begin
				bp_time[i] = 0;
				bp_val[i] = 0;
			end
		endfunction

		function int limit_pan(longint p);
			if (p > PAN_MAX) return PAN_MAX;
			if (p < -PAN_MAX) return -PAN_MAX;
			return int'(p);
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] d);
			case (idx)
				REG_PAN_POSITION: pan_pos = int'($signed(d));
				REG_PAN_LAW:      law = d[0];
				REG_HOST_SYNC:    sync_on = d[0];
				REG_MONO_INPUT:   mono = d[0];
				REG_RAMP_STEPS: begin
					ramp = d;
					cur = longint'(tgt) * 65536;
					countdown = 0;
				end
				REG_BP_COUNT: begin
					bp_count = (d[6:0] > DEPTH) ? DEPTH : d[6:0];
					seg = 0;
				end
				default: ;
			endcase
		endfunction

		// Quarter-sine gain for a pan fraction u in 0..65536, Q0.16.
		function longint sine_gain(longint u);
			longint pos, idx, frac, a, b;
			pos = u * ROM_SIZE;
			idx = pos >> 16;
			frac = pos & 16'hFFFF;
			if (idx >= ROM_SIZE) return rom[ROM_SIZE];
			a = rom[idx];
			b = rom[idx + 1];
			if (b >= a) return a + (((b - a) * frac) >> 16);
			return a - (((a - b) * frac) >> 16);
		endfunction

		function longint apply_gain(longint s, longint g);
			longint v;
			v = s * g + 32768;
			if (v >= 0) return v >>> 16;
			return -((-v + 65535) >>> 16);
		endfunction

		function int ramp_pan();
			int t;
			t = limit_pan(pan_pos);
			if (t != tgt) begin
				tgt = t;
				if (ramp == 0) begin
					cur = longint'(t) * 65536;
					countdown = 0;
				end else begin
					countdown = ramp;
					step = (longint'(t) * 65536 - cur) / longint'(ramp);
				end
			end
			if (countdown == 0) return tgt;
			countdown--;
			if (countdown != 0) cur += step;
			else cur = longint'(tgt) * 65536;
			return limit_pan(cur / 65536);
		endfunction

		function int envelope_pan(logic [31:0] t);
			longint den, num;
			if (bp_count < 2) return 0;
			while (seg + 1 < bp_count && longint'(t) > bp_time[seg + 1]) seg++;
			if (seg >= bp_count - 1) return bp_val[bp_count - 1];
			den = longint'(bp_time[seg + 1]) - longint'(bp_time[seg]);
			if (den == 0) return bp_val[seg + 1];
			num = longint'(t) - longint'(bp_time[seg]);
			return limit_pan(bp_val[seg] +
				(longint'(bp_val[seg + 1] - bp_val[seg]) * num) / den);
		endfunction

		// Notes an accepted item and queues the sample it must produce.
		function void note_item(pan_item_t it);
			int pan;
			longint u, li, ri, gl, gr;
			pan_sample_t e;
			case (it.cmd)
				CMD_ENTRY: begin
					bp_time[it.idx] = it.et;
					bp_val[it.idx] = limit_pan(it.ev);
				end
				CMD_PLAYTIME: now = it.pt;
				CMD_AUDIO: begin
					if (sync_on && bp_count > 0) begin
						pan = envelope_pan(now);
						now = now + 32'd1;
					end else begin
						pan = ramp_pan();
					end
					u = pan + 32768;
					if (law) begin
						gl = sine_gain(65536 - u);
						gr = sine_gain(u);
					end else begin
						gl = 65536 - u;
						gr = u;
					end
					li = it.l;
					ri = mono ? li : longint'(it.r);
					e.l = 24'(apply_gain(li, gl));
					e.r = 24'(apply_gain(ri, gr));
					e.pan = 16'(pan);
					due.insert(due.size(), e);
				end
				default: ;
			endcase
		endfunction

		function void check_sample(logic signed [23:0] l, logic signed [23:0] r,
				logic signed [15:0] p);
			pan_sample_t e;
			if (due.size() == 0) begin
				$error("unexpected sample left_out %0d right_out %0d", l, r);
				fails++;
				return;
			end
			e = due.pop_front();
			if (l !== e.l) begin
				$error("left_out expected %0d got %0d", e.l, l);
				fails++;
			end
			if (r !== e.r) begin
				$error("right_out expected %0d got %0d", e.r, r);
				fails++;
			end
			if (p !== e.pan) begin
				$error("pan_used expected %0d got %0d", e.pan, p);
				fails++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         command = CMD_AUDIO;
	logic signed [23:0] left_in = '0;
	logic signed [23:0] right_in = '0;
	logic [5:0]         entry_index = '0;
	logic [31:0]        entry_time = '0;
	logic signed [15:0] entry_value = '0;
	logic [31:0]        play_time = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [23:0] left_out;
	logic signed [23:0] right_out;
	logic signed [15:0] pan_used;

	pan_scoreboard sb = new();

	// Idle percentages of the sender and the receiver for the current phase.
	int tx_idle = 0;
	int rx_idle = 0;
	// The main process asks for a long receiver hold-off through this flag;
	// the receiver process counts the stretch out itself.
	bit hold_req = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	stereo_panner_with_envelope dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .left_in(left_in), .right_in(right_in),
		.entry_index(entry_index), .entry_time(entry_time),
		.entry_value(entry_value), .play_time(play_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_out(left_out), .right_out(right_out), .pan_used(pan_used)
	);

	// Receiver: ready changes on the falling edge, either at random or held
	// low for a long stretch when the main process asks for one.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Every accepted sample is checked at the rising edge that takes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_sample(left_out, right_out, pan_used);
		end
	end

	// Watchdog: a long run of cycles in which neither side moves an item
	// means the block has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one item, keeping valid high from the previous item when the
	// sender does not idle, and notes it in the scoreboard on acceptance.
	task automatic offer(pan_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		command     <= it.cmd;
		left_in     <= it.l;
		right_in    <= it.r;
		entry_index <= it.idx;
		entry_time  <= it.et;
		entry_value <= it.ev;
		play_time   <= it.pt;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	// Stops offering and waits until every expected sample has come back,
	// plus enough cycles for a trailing item that returns nothing.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	// Register writes wait until no item is in flight in the block.
	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		@(negedge clk);
		in_valid <= 1'b0;
		while ((sb.due.size() != 0) || !in_ready) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	task automatic audio(logic signed [23:0] l, logic signed [23:0] r);
		pan_item_t it;
		it = '{CMD_AUDIO, l, r, 6'($urandom), $urandom, 16'($urandom), $urandom};
		offer(it);
	endtask

	task automatic entry(int slot, logic [31:0] t, logic signed [15:0] v);
		pan_item_t it;
		it = '{CMD_ENTRY, 24'($urandom), 24'($urandom), slot[5:0], t, v, $urandom};
		offer(it);
	endtask

	task automatic seek(logic [31:0] t);
		pan_item_t it;
		it = '{CMD_PLAYTIME, 24'($urandom), 24'($urandom), 6'($urandom), $urandom,
			16'($urandom), t};
		offer(it);
	endtask

	// Rewrites the first n slots as a sorted envelope; a gap of zero gives
	// zero-length segments.
	task automatic load_envelope(int n);
		logic [31:0] t;
		t = $urandom_range(40);
		for (int k = 0; k < n; k++) begin
			entry(k, t, 16'($urandom));
			t = t + $urandom_range(40);
		end
	endtask

	// Random register setting, leaning on the extremes.
	task automatic shuffle_regs();
		int pick;
		pick = $urandom_range(5);
		write_reg(REG_PAN_POSITION, (pick == 0) ? 16'h8000 :
			(pick == 1) ? 16'h7FFF : (pick == 2) ? 16'h0000 : 16'($urandom));
		write_reg(REG_PAN_LAW, 16'($urandom_range(1)));
		write_reg(REG_HOST_SYNC, 16'($urandom_range(1)));
		write_reg(REG_MONO_INPUT, 16'($urandom_range(3) == 0));
		pick = $urandom_range(5);
		write_reg(REG_RAMP_STEPS, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
			(pick == 2) ? 16'($urandom) : 16'($urandom_range(1, 60)));
		pick = $urandom_range(6);
		write_reg(REG_BP_COUNT, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
			(pick == 2) ? 16'd64 : (pick == 3) ? 16'd127 : 16'($urandom_range(2, 64)));
	endtask

	// One burst of random items between register settings. Most items are
	// audio; the rest move the playhead or rewrite slots, and a few are noise.
	task automatic random_burst(int n);
		pan_item_t it;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			it = '{CMD_AUDIO, 24'($urandom), 24'($urandom), 6'($urandom), $urandom,
				16'($urandom), $urandom};
			if (pick < 6) begin
				it.cmd = CMD_PLAYTIME;
				it.pt = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1300);
			end else if (pick < 12) begin
				it.cmd = CMD_ENTRY;
				it.et = ($urandom_range(7) == 0) ? $urandom
					: it.idx * 20 + $urandom_range(19);
			end else if (pick < 14) begin
				it.cmd = CMD_NONE;
			end
			offer(it);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: sample extremes under the linear law, full left and right.
		write_reg(REG_PAN_LAW, 0);
		write_reg(REG_RAMP_STEPS, 0);
		write_reg(REG_PAN_POSITION, 16'h8000);
		audio(24'sh800000, 24'sh7FFFFF);
		audio(24'sh7FFFFF, 24'sh800000);
		write_reg(REG_PAN_POSITION, 16'h7FFF);
		audio(24'sh800000, 24'sh7FFFFF);
		drain();
		write_reg(REG_PAN_LAW, 1);
		audio(24'sh7FFFFF, -24'sd1);
		write_reg(REG_MONO_INPUT, 1);
		audio(24'sh800000, 24'sd5);
		seek(32'd0);
		begin
			pan_item_t it;
			it = '{CMD_NONE, 24'sd1, 24'sd1, 6'd0, 32'd0, 16'sd0, 32'd0};
			offer(it);
		end
		drain();
		// A short ramp, interrupted by a ramp length write that snaps it.
		write_reg(REG_MONO_INPUT, 0);
		write_reg(REG_RAMP_STEPS, 4);
		write_reg(REG_PAN_POSITION, 16'hC000);
		repeat (2) audio(24'sh400000, 24'sh400000);
		drain();
		write_reg(REG_RAMP_STEPS, 3);
		audio(24'sh123456, 24'shEDCBA9);

		// Fill every slot once so the envelope never reads an empty slot.
		for (int k = 0; k < DEPTH; k++) entry(k, 32'(k * 16), 16'($urandom));
		// Before the first entry, the line is extended and clamped.
		entry(0, 32'd100, 16'h8000);
		entry(1, 32'd200, 16'h7FFF);
		// Zero-length segment, then one out of order.
		entry(2, 32'd200, 16'h1000);
		entry(3, 32'd150, 16'hF000);
		drain();
		write_reg(REG_HOST_SYNC, 1);
		write_reg(REG_BP_COUNT, 1);
		audio(24'sd1000, 24'sd1000);
		drain();
		write_reg(REG_BP_COUNT, 100);
		seek(32'd10);
		audio(24'sd1000, -24'sd1000);
		seek(32'd200);
		audio(24'sd1000, 24'sd1000);
		seek(32'hFFFF_FFFE);
		repeat (3) audio(24'sd77, 24'sd77);
		seek(32'd0);
		audio(24'sd77, 24'sd77);
		drain();

		// Random part in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 22 : (ph == 1) ? 70 : 0;
			rx_idle = (ph == 0) ? 70 : (ph == 1) ? 22 : 0;
			for (int b = 0; b < 10; b++) begin
				shuffle_regs();
				if ($urandom_range(2) == 0) load_envelope($urandom_range(2, 64));
				seek($urandom_range(200));
				if (b == 3) hold_req = 1;
				random_burst(37);
				drain();
			end
		end

		drain();
		if (sb.fails == 0 && sb.due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/spe_pkg.sv
sv/spe_div.sv
sv/stereo_panner_with_envelope.sv
sim/stereo_panner_with_envelope_tb.sv
